### hw/rtl/modified_givens_apply_f32_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef MODIFIED_GIVENS_APPLY_F32_UNIT_ASSERT_SVH
`define MODIFIED_GIVENS_APPLY_F32_UNIT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define MGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MGA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/mga_pkg.sv
// ----------------------------------------------------------------------------
// mga_pkg
// Shared types, register indexes and float helpers for the rotation unit.
// ----------------------------------------------------------------------------
package mga_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegH11 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegH21 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegH12 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegH22 = 3'd4;

  typedef enum logic [1:0] {
    ModePass = 2'd0,
    ModeFull = 2'd1,
    ModeUnit = 2'd2,
    ModeDiag = 2'd3
  } mode_e;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } pair_t;

  // Word type for the multiply and add halves; no module in the project uses it.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
    mode_e       mode;
  } prod_t;

  function automatic logic is_nan(logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

endpackage

### hw/rtl/mga_if.sv
// ----------------------------------------------------------------------------
// mga_if
// Valid/ready channel carrying one element pair word.
// ----------------------------------------------------------------------------
interface mga_if;
  logic valid;
  logic ready;
  logic [31:0] x;
  logic [31:0] y;
  logic        last;

  modport source (output valid, output x, output y, output last, input ready);
  modport sink (input valid, input x, input y, input last, output ready);
endinterface

### hw/rtl/modified_givens_apply_f32_unit.sv
// Each word passes through the input register, the multiplier stages and then the adder stages.
// Throughput: one pair per cycle while the output is not stalled; the four multipliers and two adders are pipelined.
// A stall at the output freezes every stage together, so nothing is lost.
// Reset clears the valid bits and the configuration registers (mode pass-through, coefficients 0).
// ----------------------------------------------------------------------------
// modified_givens_apply_f32_unit
// Applies a configured modified Givens rotation to a stream of float pairs.
// ----------------------------------------------------------------------------
module modified_givens_apply_f32_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mga_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mga_pkg::CfgDataW-1:0] cfg_data_i,
  mga_if.sink                          in_if,
  mga_if.source                        out_if
);
  import mga_pkg::*;

  // Configuration registers.
  mode_e       mode_q;
  logic [31:0] h11_q, h21_q, h12_q, h22_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePass;
      h11_q <= '0; h21_q <= '0; h12_q <= '0; h22_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode: mode_q <= mode_e'(cfg_data_i[1:0]);
        RegH11:  h11_q <= cfg_data_i;
        RegH21:  h21_q <= cfg_data_i;
        RegH12:  h12_q <= cfg_data_i;
        RegH22:  h22_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage advances together when the output can move.
  logic [4:0] vld_q;
  logic       adv;
  assign adv = !vld_q[4] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[3:0], in_if.valid};
  end

  // Input register.
  pair_t in_q;
  mode_e m0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= '{x: in_if.x, y: in_if.y, last: in_if.last};
      m0_q <= mode_q;
    end
  end

  // Multiplier coefficient operands; the same in every mode.
  logic [31:0] ma_b, mb_b, mc_b, md_b;
  always_comb begin
    ma_b = h11_q; mb_b = h12_q; mc_b = h21_q; md_b = h22_q;
  end

  logic [31:0] pa, pb, pc, pd;
  mga_fmul u_mul_a (.clk_i, .en_i(adv), .a_i(in_q.x), .b_i(ma_b), .p_o(pa));
  mga_fmul u_mul_b (.clk_i, .en_i(adv), .a_i(in_q.y), .b_i(mb_b), .p_o(pb));
  mga_fmul u_mul_c (.clk_i, .en_i(adv), .a_i(in_q.x), .b_i(mc_b), .p_o(pc));
  mga_fmul u_mul_d (.clk_i, .en_i(adv), .a_i(in_q.y), .b_i(md_b), .p_o(pd));

  // Side data riding along with the multipliers.
  pair_t s1_q, s2_q;
  mode_e m1_q, m2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= in_q; m1_q <= m0_q;
      s2_q <= s1_q; m2_q <= m1_q;
    end
  end

  // Adder operand selection per mode.
  logic [31:0] xa, xb, ya, yb;
  always_comb begin
    xa = pa; xb = pb; ya = pc; yb = pd;
    case (m2_q)
      ModeUnit: begin xa = s2_q.x; yb = s2_q.y; end
      ModeDiag: begin xb = s2_q.y; ya = pd; yb = {~s2_q.x[31], s2_q.x[30:0]}; end
      default: ;
    endcase
  end

  logic [31:0] sx, sy;
  mga_fadd u_add_x (.clk_i, .en_i(adv), .a_i(xa), .b_i(xb), .s_o(sx));
  mga_fadd u_add_y (.clk_i, .en_i(adv), .a_i(ya), .b_i(yb), .s_o(sy));

  pair_t s3_q, s4_q;
  mode_e m3_q, m4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q <= s2_q; m3_q <= m2_q;
      s4_q <= s3_q; m4_q <= m3_q;
    end
  end

  // Output word.
  assign out_if.valid = vld_q[4];
  assign out_if.x = (m4_q == ModePass) ? s4_q.x : sx;
  assign out_if.y = (m4_q == ModePass) ? s4_q.y : sy;
  assign out_if.last = s4_q.last;
endmodule

### hw/rtl/mga_fmul.sv
// ----------------------------------------------------------------------------
// mga_fmul
// Two-stage single-precision multiplier, round to nearest even.
// ----------------------------------------------------------------------------
module mga_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);
  import mga_pkg::*;

  // Stage one: unpack, mantissa product, exponent sum, specials.
  logic        s_d, s_q;
  logic signed [10:0] e_d, e_q;
  logic [47:0] m_d, m_q;
  logic [1:0]  sp_d, sp_q;  // 0 normal, 1 zero, 2 inf, 3 nan
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic        za, zb, ia, ib;

  always_comb begin
    ea = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    za = a_i[30:0] == 31'd0;
    zb = b_i[30:0] == 31'd0;
    ia = a_i[30:0] == 31'h7F80_0000;
    ib = b_i[30:0] == 31'h7F80_0000;
    s_d = a_i[31] ^ b_i[31];
    m_d = ma * mb;
    e_d = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
    if (is_nan(a_i) || is_nan(b_i) || (ia && zb) || (ib && za)) sp_d = 2'd3;
    else if (ia || ib) sp_d = 2'd2;
    else if (za || zb) sp_d = 2'd1;
    else sp_d = 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d; e_q <= e_d; m_q <= m_d; sp_q <= sp_d;
    end
  end

  // Stage two: normalize, denormalize, round.
  logic [31:0] p_d, p_q;
  logic [5:0]  lz;
  logic [47:0] mn;
  logic signed [11:0] en;
  logic [6:0]  rs;
  logic [72:0] sh;
  logic [23:0] keep;
  logic        g, st, inc;
  logic [24:0] rnd;
  logic signed [11:0] ef;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m_q[i]) lz = 6'(47 - i);
    end
    mn = m_q << lz;
    // value = mn[47:0] * 2^(e - 127 - 46 ... ); leading bit at 47 is exponent e+1-lz
    en = 12'(e_q) + 12'sd1 - 12'($unsigned(lz));
    rs = 7'd0;
    if (en < 12'sd1) rs = (12'sd1 - en > 12'sd48) ? 7'd48 : 7'(12'sd1 - en);
    sh = {mn, 25'd0} >> rs;
    keep = sh[72:49];
    g = sh[48];
    st = |sh[47:0];
    inc = g && (st || keep[0]);
    rnd = {1'b0, keep} + {24'd0, inc};
    ef = (en < 12'sd1) ? 12'sd0 : en;
    if (rnd[24]) begin
      ef = ef + 12'sd1;
      rnd = rnd >> 1;
    end else if (ef == 12'sd0 && rnd[23]) begin
      ef = 12'sd1;
    end
    if (sp_q == 2'd3) p_d = CanonNan;
    else if (sp_q == 2'd2) p_d = {s_q, 31'h7F80_0000};
    else if (sp_q == 2'd1 || m_q == 48'd0) p_d = {s_q, 31'd0};
    else if (ef >= 12'sd255) p_d = {s_q, 31'h7F80_0000};
    else p_d = {s_q, ef[7:0], rnd[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= p_d;
  end
  assign p_o = p_q;
endmodule

### hw/rtl/mga_fadd.sv
// ----------------------------------------------------------------------------
// mga_fadd
// Two-stage single-precision adder, round to nearest even.
// ----------------------------------------------------------------------------
module mga_fadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);
  import mga_pkg::*;

  // Stage one: order operands, align and add with sticky bits.
  logic        big_s, sm_s, sub;
  logic [7:0]  be, se;
  logic [23:0] bm, smm;
  logic [8:0]  d;
  logic [50:0] al;
  logic [27:0] sa;
  logic [28:0] sum_d, sum_q;
  logic        sg_d, sg_q;
  logic [7:0]  e_d, e_q;
  logic [1:0]  sp_d, sp_q;  // 0 normal, 1 nan, 2 inf
  logic [31:0] spv_d, spv_q;
  logic        ia, ib;

  always_comb begin
    if (a_i[30:0] >= b_i[30:0]) begin
      big_s = a_i[31]; be = a_i[30:23]; bm = {a_i[30:23] != 8'd0, a_i[22:0]};
      sm_s = b_i[31]; se = b_i[30:23]; smm = {b_i[30:23] != 8'd0, b_i[22:0]};
    end else begin
      big_s = b_i[31]; be = b_i[30:23]; bm = {b_i[30:23] != 8'd0, b_i[22:0]};
      sm_s = a_i[31]; se = a_i[30:23]; smm = {a_i[30:23] != 8'd0, a_i[22:0]};
    end
    d = {1'b0, (be == 8'd0) ? 8'd1 : be} - {1'b0, (se == 8'd0) ? 8'd1 : se};
    al = {smm, 27'd0} >> ((d > 9'd27) ? 9'd27 : d);
    sa = {al[50:24], |al[23:0]};
    sub = big_s ^ sm_s;
    sum_d = sub ? ({1'b0, bm, 4'd0} - {1'b0, sa}) : ({1'b0, bm, 4'd0} + {1'b0, sa});
    e_d = (be == 8'd0) ? 8'd1 : be;
    sg_d = big_s;
    ia = a_i[30:0] == 31'h7F80_0000;
    ib = b_i[30:0] == 31'h7F80_0000;
    spv_d = {a_i[31], 31'h7F80_0000};
    if (is_nan(a_i) || is_nan(b_i) || (ia && ib && (a_i[31] != b_i[31]))) sp_d = 2'd1;
    else if (ia) sp_d = 2'd2;
    else if (ib) begin sp_d = 2'd2; spv_d = {b_i[31], 31'h7F80_0000}; end
    else sp_d = 2'd0;
    // Exact zero: +0 unless both operands are -0.
    if (sp_d == 2'd0 && sum_d == 29'd0) sg_d = a_i[31] & b_i[31];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d; sg_q <= sg_d; e_q <= e_d; sp_q <= sp_d; spv_q <= spv_d;
    end
  end

  // Stage two: normalize and round.
  logic [4:0]  lz;
  logic [28:0] nm;
  logic signed [10:0] en;
  logic [4:0]  adj;
  logic [23:0] keep;
  logic        g, st, inc;
  logic [24:0] rnd;
  logic signed [10:0] ef;
  logic [31:0] s_d, s_q;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 29; i++) begin
      if (sum_q[i]) lz = 5'(28 - i);
    end
    // Leading bit at 28 means exponent e+1; limit shift to stay at exponent 1.
    en = 11'($unsigned(e_q)) + 11'sd1 - 11'($unsigned(lz));
    adj = lz;
    if (en < 11'sd1) begin
      adj = 5'(11'($unsigned(lz)) + en - 11'sd1);
      en = 11'sd0;
    end
    nm = sum_q << adj;
    keep = nm[28:5];
    g = nm[4];
    st = |nm[3:0];
    inc = g && (st || keep[0]);
    rnd = {1'b0, keep} + {24'd0, inc};
    ef = en;
    if (rnd[24]) begin
      ef = (ef == 11'sd0) ? 11'sd2 : ef + 11'sd1;
      rnd = rnd >> 1;
    end else if (ef == 11'sd0 && rnd[23]) begin
      ef = 11'sd1;
    end
    if (sp_q == 2'd1) s_d = CanonNan;
    else if (sp_q == 2'd2) s_d = spv_q;
    else if (sum_q == 29'd0) s_d = {sg_q, 31'd0};
    else if (ef >= 11'sd255) s_d = {sg_q, 31'h7F80_0000};
    else s_d = {sg_q, ef[7:0], rnd[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s_q <= s_d;
  end
  assign s_o = s_q;
endmodule

### hw/rtl/mga_checker.sv
// ----------------------------------------------------------------------------
// mga_checker
// Port-level checks on the rotation unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "modified_givens_apply_f32_unit_assert.svh"
module mga_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x
);
  // A stalled output word stays valid.
  `MGA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  // The input is never refused while the output is free.
  `MGA_ASSERT_IMP(a_in_ready, clk_i, rst_ni, !out_valid || out_ready, in_ready)
  // A word stalled at the output also stalls the input.
  `MGA_ASSERT_IMP(a_back_press, clk_i, rst_ni, out_valid && !out_ready, !in_ready)
  // A stalled word keeps its x value.
  `MGA_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid && !out_ready, $stable(out_x))
endmodule

bind modified_givens_apply_f32_unit mga_checker u_mga_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_x(out_if.x)
);

### sim/modified_givens_apply_f32_unit_tb.sv
// ----------------------------------------------------------------------------
// modified_givens_apply_f32_unit_tb
// Streams float pairs through the rotation unit in all four modes with
// extreme and random coefficients and random handshake gaps. Every result
// word is checked against a bit-exact single-precision predictor.
// ----------------------------------------------------------------------------
module modified_givens_apply_f32_unit_tb;
  import mga_pkg::*;

  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned NumPhases = 12;
  localparam int unsigned WordsPerPhase = 166;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  mga_if in_ch ();
  mga_if out_ch ();

  modified_givens_apply_f32_unit u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the configuration registers.
  mode_e       rot_mode = ModePass;
  logic [31:0] h11 = '0, h21 = '0, h12 = '0, h22 = '0;

  pair_t pending_pairs[$];
  pair_t rotated_pairs[$];
  int    errors = 0;
  int    words_sent = 0;
  int    words_checked = 0;
  int    cycle_count = 0;
  logic  took_word = 1'b0;
  logic  hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Single-precision arithmetic, round to nearest even.
  // --------------------------------------------------------------------------
  function automatic logic f32_nan(logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic f32_inf(logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
  endfunction

  function automatic logic f32_zero(logic [31:0] f);
    return f[30:0] == 31'd0;
  endfunction

  // Splits a finite value into an integer significand and the weight of its lsb.
  function automatic void f32_split(input logic [31:0] f, output logic [63:0] m,
                                    output int e);
    if (f[30:23] == 8'd0) begin
      m = {41'd0, f[22:0]};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, f[22:0]};
      e = int'(f[30:23]) - 150;
    end
  endfunction

  // Rounds the exact value sig * 2^e to single precision.
  function automatic logic [31:0] f32_round(logic sgn, int e, logic [63:0] sig);
    int p, sh, be;
    logic [63:0] q, rem, half;
    p = 63;
    while (!sig[p]) p--;
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh <= 0) begin
      q = sig << (-sh);
    end else if (sh > 64) begin
      q = '0;
    end else begin
      q = sig >> sh;
      rem = sig - (q << sh);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    if (q[24]) begin
      q = q >> 1;
      sh++;
    end
    if (!q[23]) return {sgn, 8'd0, q[22:0]};
    be = e + sh + 150;
    if (be >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, be[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic [63:0] ma, mb;
    int ea, eb;
    logic sgn;
    sgn = a[31] ^ b[31];
    if (f32_nan(a) || f32_nan(b)) return CanonNan;
    if (f32_inf(a) || f32_inf(b)) begin
      if (f32_zero(a) || f32_zero(b)) return CanonNan;
      return {sgn, 8'hFF, 23'd0};
    end
    if (f32_zero(a) || f32_zero(b)) return {sgn, 31'd0};
    f32_split(a, ma, ea);
    f32_split(b, mb, eb);
    return f32_round(sgn, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic [63:0] ma, mb, mt;
    int ea, eb, et, d;
    longint s;
    logic sa, sb, st;
    if (f32_nan(a) || f32_nan(b)) return CanonNan;
    if (f32_inf(a) && f32_inf(b)) return (a[31] != b[31]) ? CanonNan : a;
    if (f32_inf(a)) return a;
    if (f32_inf(b)) return b;
    if (f32_zero(a) && f32_zero(b)) return {a[31] & b[31], 31'd0};
    f32_split(a, ma, ea);
    f32_split(b, mb, eb);
    sa = a[31];
    sb = b[31];
    if (eb > ea) begin
      mt = ma; ma = mb; mb = mt;
      et = ea; ea = eb; eb = et;
      st = sa; sa = sb; sb = st;
    end
    d = ea - eb;
    // A far smaller operand only matters as a sticky bit below the result lsb.
    if (d > 30) begin
      mb = (mb != 0) ? 64'd1 : 64'd0;
      eb = ea - 30;
      d = 30;
    end
    ma = ma << d;
    s = (sa ? -longint'(ma) : longint'(ma)) + (sb ? -longint'(mb) : longint'(mb));
    if (s == 0) return 32'd0;
    return f32_round(s < 0, eb, (s < 0) ? 64'(-s) : 64'(s));
  endfunction

  // Expected result word for one input pair under the current settings.
  function automatic pair_t rotate_pair(pair_t w);
    pair_t r;
    r = w;
    case (rot_mode)
      ModeFull: begin
        r.x = f32_add(f32_mul(w.x, h11), f32_mul(w.y, h12));
        r.y = f32_add(f32_mul(w.x, h21), f32_mul(w.y, h22));
      end
      ModeUnit: begin
        r.x = f32_add(w.x, f32_mul(w.y, h12));
        r.y = f32_add(f32_mul(w.x, h21), w.y);
      end
      ModeDiag: begin
        r.x = f32_add(f32_mul(w.x, h11), w.y);
        r.y = f32_add(f32_mul(w.y, h22), {~w.x[31], w.x[30:0]});
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus values.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] edge_f32();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7F7F_FFFF;
      5: return 32'h0000_0001;
      6: return 32'h007F_FFFF;
      7: return 32'h0080_0000;
      8: return 32'hFFFF_FFFF;
      9: return 32'h3F80_0000;
      10: return 32'h7F80_0001;
      default: return 32'hFF7F_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rand_f32();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return edge_f32();
      1: return r;
      2: return {r[31], 8'd0, r[22:0]};
      3: return {r[31], 8'($urandom_range(200, 254)), r[22:0]};
      default: return {r[31], 8'($urandom_range(100, 154)), r[22:0]};
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t w;
    w.x = rand_f32();
    w.last = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      // Exact cancellation and near-equal operands.
      0: w.y = {~w.x[31], w.x[30:0]};
      1: w.y = w.x ^ 32'($urandom_range(0, 3));
      default: w.y = rand_f32();
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes, made only while the unit is idle.
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      RegMode: rot_mode = mode_e'(data[1:0]);
      RegH11: h11 = data;
      RegH21: h21 = data;
      RegH12: h12 = data;
      RegH22: h22 = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_rotation(mode_e m, logic [31:0] c11, logic [31:0] c21,
                              logic [31:0] c12, logic [31:0] c22);
    logic [31:0] noise;
    noise = $urandom;
    // Upper bits of the mode word must be ignored.
    write_reg(RegMode, {noise[31:2], m});
    write_reg(RegH11, c11);
    write_reg(RegH21, c21);
    write_reg(RegH12, c12);
    write_reg(RegH22, c22);
    // A write to an index past the register list changes nothing.
    write_reg(RegH22 + 3'($urandom_range(1, 3)), $urandom);
  endtask

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || rotated_pairs.size() != 0 || in_ch.valid)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps in between.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      rotated_pairs.push_back(rotate_pair({in_ch.x, in_ch.y, in_ch.last}));
      took_word = 1'b1;
      words_sent++;
    end
  end

  always @(negedge clk_i) begin
    pair_t w;
    if (rst_ni && !(in_ch.valid && !took_word)) begin
      took_word = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid = 1'b0;
      end else if (pending_pairs.size() != 0) begin
        w = pending_pairs.pop_front();
        in_ch.x = w.x;
        in_ch.y = w.y;
        in_ch.last = w.last;
        in_ch.valid = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall patterns of random length; one long hold-off.
  // --------------------------------------------------------------------------
  int hold_cnt = 0;
  int pat_left = 0;
  int pat_kind = 0;

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready = 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_kind = $urandom_range(0, 3);
        pat_left = $urandom_range(16, 80);
      end
      pat_left--;
      case (pat_kind)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = ($urandom_range(0, 4) == 0);
        default: out_ch.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pair_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (rotated_pairs.size() == 0) begin
        $error("result word with no pair outstanding: x=%h y=%h", out_ch.x, out_ch.y);
        errors++;
      end else begin
        want = rotated_pairs.pop_front();
        words_checked++;
        if (out_ch.x !== want.x) begin
          $error("x_out: expected %h, got %h", want.x, out_ch.x);
          errors++;
        end
        if (out_ch.y !== want.y) begin
          $error("y_out: expected %h, got %h", want.y, out_ch.y);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > TimeoutCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] dir_x[6];
    logic [31:0] dir_y[6];
    pair_t w;
    mode_e m;
    in_ch.valid = 1'b0;
    in_ch.x = '0;
    in_ch.y = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pairs: signed zeros, infinity, NaN payloads, overflow,
    // smallest subnormals and exact cancellation, in every mode.
    dir_x = '{32'h0000_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
              32'h0000_0001, 32'h3F80_0000};
    dir_y = '{32'h8000_0000, 32'h3F80_0000, 32'h7F80_0001, 32'h7F7F_FFFF,
              32'h8000_0001, 32'hBF80_0000};
    for (int k = 0; k < 4; k++) begin
      set_rotation(mode_e'(k), 32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000,
                   32'h3F00_0000);
      for (int i = 0; i < 6; i++) begin
        w.x = dir_x[i];
        w.y = dir_y[i];
        w.last = i[0];
        pending_pairs.push_back(w);
      end
      wait_idle();
    end

    // Random phases; every third one uses extreme coefficients.
    for (int p = 0; p < NumPhases; p++) begin
      m = mode_e'(p % 4);
      if (p % 3 == 0)
        set_rotation(m, edge_f32(), edge_f32(), edge_f32(), edge_f32());
      else
        set_rotation(m, rand_f32(), rand_f32(), rand_f32(), rand_f32());
      for (int i = 0; i < WordsPerPhase; i++) pending_pairs.push_back(rand_pair());
      // Long output stall while the sender keeps offering words.
      if (p == 5) hold_req = 1'b1;
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d result words from %0d sent pairs over %0d settings.",
             words_checked, words_sent, NumPhases + 4);
    if (errors == 0 && rotated_pairs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mga_pkg.sv
hw/rtl/mga_if.sv
hw/rtl/mga_fmul.sv
hw/rtl/mga_fadd.sv
hw/rtl/modified_givens_apply_f32_unit.sv
hw/rtl/mga_checker.sv
sim/modified_givens_apply_f32_unit_tb.sv
